### rtl/tcw_pkg.sv
// shared types, codes and defaults for the text console writer
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int TAB_WIDTH_DEF = 4;

    localparam int IN_W  = 32;
    localparam int OUT_W = 32;

    // action codes
    localparam logic [2:0] ACT_CHAR   = 3'd0;
    localparam logic [2:0] ACT_CLEAR  = 3'd1;
    localparam logic [2:0] ACT_THEME  = 3'd2;
    localparam logic [2:0] ACT_COLOUR = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    // control characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] ATTR_DARK  = 8'h07;
    localparam logic [7:0] ATTR_LIGHT = 8'hF0;

    // sweep kinds
    localparam logic [1:0] SW_FILL    = 2'd0;
    localparam logic [1:0] SW_RECOLOR = 2'd1;
    localparam logic [1:0] SW_SCROLL  = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
        logic sweep_go;
        logic boot;
        logic out_load;
    } tcw_cmd_t;

    typedef struct packed {
        logic need_sweep;
        logic need_read;
        logic sweep_done;
        logic out_free;
    } tcw_status_t;

endpackage

`default_nettype wire

### rtl/tcw_ctrl.sv
// controller state machine of the text console writer
`default_nettype none

module tcw_ctrl import tcw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output tcw_cmd_t         cmd,
    input  wire tcw_status_t st
);

    localparam logic [2:0] S_BOOT      = 3'd0;
    localparam logic [2:0] S_BOOT_WAIT = 3'd1;
    localparam logic [2:0] S_IDLE      = 3'd2;
    localparam logic [2:0] S_EXEC      = 3'd3;
    localparam logic [2:0] S_SWEEP     = 3'd4;
    localparam logic [2:0] S_READ      = 3'd5;
    localparam logic [2:0] S_OUT       = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_BOOT:
            begin
                cmd.sweep_go = 1'b1;
                cmd.boot     = 1'b1;
                state_next   = S_BOOT_WAIT;
            end
            S_BOOT_WAIT:
            begin
                if (st.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec     = 1'b1;
                cmd.sweep_go = st.need_sweep;
                if (st.need_sweep)
                begin
                    state_next = S_SWEEP;
                end
                else if (st.need_read)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SWEEP:
            begin
                if (st.sweep_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_BOOT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tcw_datapath.sv
// datapath: cell store, cursor, colour, sweep engine and result register
`default_nettype none

module tcw_datapath import tcw_pkg::*;
#(
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int TAB_WIDTH = TAB_WIDTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire tcw_cmd_t         cmd,
    output tcw_status_t           st,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int N   = ROWS * COLUMNS;
    localparam int AW  = $clog2(N);
    localparam int AXW = $clog2(N + COLUMNS);
    localparam int CW  = $clog2(COLUMNS);
    localparam int CXW = $clog2(COLUMNS + TAB_WIDTH);
    localparam int RW  = $clog2(ROWS);
    localparam int RXW = $clog2(ROWS + 1);

    // cell store, {attr, char}
    logic [15:0] mem [N];

    logic [IN_W-1:0] item_reg;
    logic [CW-1:0]   cur_col_reg;
    logic [RW-1:0]   cur_row_reg;
    logic [7:0]      colour_reg;
    logic            theme_reg;
    logic            rd_hit_reg;
    logic [15:0]     rdata_reg;

    logic            active_reg;
    logic [AW-1:0]   issue_idx_reg;
    logic [1:0]      mode_reg;
    logic            wr_valid_reg;
    logic            wr_last_reg;
    logic            wr_blank_reg;
    logic [AW-1:0]   wr_idx_reg;

    logic            out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    // item fields
    logic [2:0] it_action;
    logic [7:0] it_char;
    logic [3:0] it_fg;
    logic [3:0] it_bg;
    logic       it_theme;
    logic [4:0] it_row;
    logic [6:0] it_col;

    assign it_action = item_reg[2:0];
    assign it_char   = item_reg[10:3];
    assign it_fg     = item_reg[14:11];
    assign it_bg     = item_reg[18:15];
    assign it_theme  = item_reg[19];
    assign it_row    = item_reg[24:20];
    assign it_col    = item_reg[31:25];

    // next tab stop for every column
    logic [CXW-1:0] tab_tbl [COLUMNS];

    for (genvar g = 0; g < COLUMNS; g++)
    begin : g_tab
        assign tab_tbl[g] = CXW'(((g / TAB_WIDTH) + 1) * TAB_WIDTH);
    end

    // character write decode
    logic [CXW-1:0] col_step;
    logic [RXW-1:0] row_step;
    logic [CXW-1:0] col_wrap;
    logic [RXW-1:0] row_wrap;
    logic           cw_en;
    logic [CW-1:0]  cw_col;
    logic [7:0]     cw_char;
    logic           scroll_need;
    logic [CW-1:0]  new_col;
    logic [RW-1:0]  new_row;

    always_comb
    begin
        col_step = CXW'(cur_col_reg);
        row_step = RXW'(cur_row_reg);
        cw_en    = 1'b0;
        cw_col   = cur_col_reg;
        cw_char  = CH_SPACE;
        case (it_char)
            CH_LF:
            begin
                col_step = '0;
                row_step = RXW'(cur_row_reg) + RXW'(1);
            end
            CH_CR:
            begin
                col_step = '0;
            end
            CH_TAB:
            begin
                col_step = tab_tbl[cur_col_reg];
            end
            CH_BS:
            begin
                if (cur_col_reg != '0)
                begin
                    col_step = CXW'(cur_col_reg) - CXW'(1);
                    cw_en    = 1'b1;
                    cw_col   = cur_col_reg - CW'(1);
                end
            end
            default:
            begin
                cw_en    = 1'b1;
                cw_char  = it_char;
                col_step = CXW'(cur_col_reg) + CXW'(1);
            end
        endcase
        col_wrap = col_step;
        row_wrap = row_step;
        if (col_step >= CXW'(COLUMNS))
        begin
            col_wrap = '0;
            row_wrap = row_step + RXW'(1);
        end
        scroll_need = (row_wrap >= RXW'(ROWS));
        new_col     = col_wrap[CW-1:0];
        new_row     = scroll_need ? RW'(ROWS - 1) : row_wrap[RW-1:0];
    end

    logic [AW-1:0] cw_addr;
    logic [AW-1:0] rd_cell_addr;
    logic          rd_hit;

    assign cw_addr      = AW'(cur_row_reg) * AW'(COLUMNS) + AW'(cw_col);
    assign rd_cell_addr = AW'(it_row) * AW'(COLUMNS) + AW'(it_col);
    assign rd_hit       = (32'(it_row) < ROWS) && (32'(it_col) < COLUMNS);

    assign st.need_sweep = (it_action == ACT_CLEAR) || (it_action == ACT_THEME)
                           || ((it_action == ACT_CHAR) && scroll_need);
    assign st.need_read  = (it_action == ACT_READ) && rd_hit;
    assign st.sweep_done = wr_valid_reg && wr_last_reg;
    assign st.out_free   = !out_valid_reg || m_tready;

    // sweep read side
    logic [AXW-1:0] src;
    logic           src_ok;
    logic [1:0]     mode_pick;

    assign src    = AXW'(issue_idx_reg)
                    + ((mode_reg == SW_SCROLL) ? AXW'(COLUMNS) : AXW'(0));
    assign src_ok = (src < AXW'(N));

    always_comb
    begin
        mode_pick = SW_SCROLL;
        if (cmd.boot || (it_action == ACT_CLEAR))
        begin
            mode_pick = SW_FILL;
        end
        else if (it_action == ACT_THEME)
        begin
            mode_pick = SW_RECOLOR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            issue_idx_reg <= '0;
            mode_reg      <= SW_FILL;
            wr_valid_reg  <= 1'b0;
            wr_last_reg   <= 1'b0;
        end
        else
        begin
            wr_valid_reg <= active_reg;
            wr_last_reg  <= (issue_idx_reg == AW'(N - 1));
            if (cmd.sweep_go)
            begin
                active_reg    <= 1'b1;
                issue_idx_reg <= '0;
                mode_reg      <= mode_pick;
            end
            else if (active_reg)
            begin
                if (issue_idx_reg == AW'(N - 1))
                begin
                    active_reg <= 1'b0;
                end
                issue_idx_reg <= issue_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_idx_reg   <= issue_idx_reg;
        wr_blank_reg <= (mode_reg == SW_FILL) || !src_ok;
    end

    // memory ports
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = rd_cell_addr;
        if (active_reg)
        begin
            rd_en   = src_ok;
            rd_addr = src[AW-1:0];
        end
        else if (cmd.exec && st.need_read)
        begin
            rd_en = 1'b1;
        end
    end

    always_comb
    begin
        we      = 1'b0;
        wr_addr = cw_addr;
        wr_data = {colour_reg, cw_char};
        if (wr_valid_reg)
        begin
            we      = 1'b1;
            wr_addr = wr_idx_reg;
            if (wr_blank_reg)
            begin
                wr_data = {colour_reg, CH_SPACE};
            end
            else if (mode_reg == SW_RECOLOR)
            begin
                wr_data = {colour_reg, rdata_reg[7:0]};
            end
            else
            begin
                wr_data = rdata_reg;
            end
        end
        else if (cmd.exec && (it_action == ACT_CHAR))
        begin
            we = cw_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // item capture and command execution
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= s_tdata;
        end
        if (cmd.exec)
        begin
            rd_hit_reg <= st.need_read;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            colour_reg  <= ATTR_DARK;
            theme_reg   <= 1'b0;
        end
        else if (cmd.exec)
        begin
            case (it_action)
                ACT_CHAR:
                begin
                    cur_col_reg <= new_col;
                    cur_row_reg <= new_row;
                end
                ACT_CLEAR:
                begin
                    cur_col_reg <= '0;
                    cur_row_reg <= '0;
                    colour_reg  <= theme_reg ? ATTR_LIGHT : ATTR_DARK;
                end
                ACT_THEME:
                begin
                    theme_reg  <= it_theme;
                    colour_reg <= it_theme ? ATTR_LIGHT : ATTR_DARK;
                end
                ACT_COLOUR:
                begin
                    colour_reg <= {it_bg, it_fg};
                end
                default:
                begin
                    colour_reg <= colour_reg;
                end
            endcase
        end
    end

    // result register
    logic [7:0] res_char;
    logic [7:0] res_attr;

    assign res_char = rd_hit_reg ? rdata_reg[7:0]  : 8'h00;
    assign res_attr = rd_hit_reg ? rdata_reg[15:8] : 8'h00;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {4'b0000, res_attr, res_char,
                             5'(cur_row_reg), 7'(cur_col_reg)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_valid_reg && cmd.exec))
        else $error("sweep write collides with a command");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_col_reg) < COLUMNS)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_row_reg) < ROWS)
        else $error("cursor row out of range");

    a_sweep_follows: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> $past(active_reg))
        else $error("sweep write without a preceding read slot");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

endmodule

`default_nettype wire

### rtl/text_console_writer.sv
// top level of the text console writer
//
//  channel  dir  tdata fields (lsb first)                               accepted when
//  s_axis   in   action[3] char_code[8] fg[4] bg[4] theme[1] row[5]      s_tvalid & s_tready
//                col[7]
//  m_axis   out  cursor_col[7] cursor_row[5] cell_char[8] cell_attr[8]   m_tvalid & m_tready
//                pad[4]
//
// set colour, unused actions and plain character writes pass the execute and output states,
// a cell read adds a read state; clear, theme and scrolling writes walk the store, one cell
// per cycle through the single write port
// after reset a clearing pass over every cell runs before the first item
// a result waits in the output register; the next item is taken meanwhile and
// its result is held until the register frees
`default_nettype none

module text_console_writer import tcw_pkg::*;
#(
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int TAB_WIDTH = TAB_WIDTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // action, char_code, fg, bg, theme, row, col
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // cursor_col, cursor_row, cell_char, cell_attr, zero pad
    output logic [OUT_W-1:0]       m_tdata
);

    tcw_cmd_t    cmd;
    tcw_status_t st;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .st       (st)
    );

    tcw_datapath #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
